### sv/psd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the point to segment distance core
// Holds the nearest-part codes and the fixed width of the distance result.
// ----------------------------------------------------------------------------
package psd_pkg;

    // width of the reported distance, fixed by the result format
    localparam int DIST_W = 33;

    // which part of the segment lies nearest to the point
    typedef enum logic [1:0] {
        PART_START    = 2'd0,
        PART_END      = 2'd1,
        PART_INTERIOR = 2'd2
    } t_part;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

### sv/psd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_front: geometry front end
// Forms differences, products, dot, squared length, cross and squared
// endpoint distances, classifies the request and squares the cross product
// in split halves. Five register stages.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int CoordW = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic signed [CoordW-1:0]    i_px,
    input  wire logic signed [CoordW-1:0]    i_py,
    input  wire logic signed [CoordW-1:0]    i_ax,
    input  wire logic signed [CoordW-1:0]    i_ay,
    input  wire logic signed [CoordW-1:0]    i_bx,
    input  wire logic signed [CoordW-1:0]    i_by,
    output logic                             o_valid,
    output logic [2*(CoordW+1)-1:0]          o_rem,
    output logic [2*(CoordW+1)-1:0]          o_low,
    output logic [2*(CoordW+1)-1:0]          o_len,
    output logic [2*(CoordW+1)-1:0]          o_d2,
    output psd_pkg::t_part                   o_part
);
    localparam int DW   = CoordW + 1;
    localparam int PW   = 2 * DW;
    localparam int DotW = PW + 1;
    localparam int LW   = PW;
    localparam int SqW  = 2 * LW;

    // stage 1: differences
    logic              r_v1;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d, r_e, r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= DW'(i_px) - DW'(i_ax);
            r_b <= DW'(i_py) - DW'(i_ay);
            r_c <= DW'(i_bx) - DW'(i_ax);
            r_d <= DW'(i_by) - DW'(i_ay);
            r_e <= DW'(i_px) - DW'(i_bx);
            r_f <= DW'(i_py) - DW'(i_by);
        end
    end

    // stage 2: products
    logic              r_v2;
    logic signed [PW-1:0] r_ac, r_bd, r_ad, r_bc, r_cc, r_dd, r_aa, r_bb, r_ee, r_ff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac <= r_a * r_c;
            r_bd <= r_b * r_d;
            r_ad <= r_a * r_d;
            r_bc <= r_b * r_c;
            r_cc <= r_c * r_c;
            r_dd <= r_d * r_d;
            r_aa <= r_a * r_a;
            r_bb <= r_b * r_b;
            r_ee <= r_e * r_e;
            r_ff <= r_f * r_f;
        end
    end

    // stage 3: dot, length, cross magnitude, endpoint squares
    logic                  r_v3;
    logic signed [DotW-1:0] r_dot;
    logic [LW-1:0]         r_len, r_cmag, r_d2a, r_d2b;
    logic signed [DotW-1:0] n_cross;

    assign n_cross = DotW'(r_ad) - DotW'(r_bc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot  <= DotW'(r_ac) + DotW'(r_bd);
            r_len  <= LW'(DotW'(r_cc) + DotW'(r_dd));
            r_cmag <= LW'(n_cross[DotW-1] ? -n_cross : n_cross);
            r_d2a  <= LW'(DotW'(r_aa) + DotW'(r_bb));
            r_d2b  <= LW'(DotW'(r_ee) + DotW'(r_ff));
        end
    end

    // stage 4: classify and form the partial squares of the cross
    logic            r_v4;
    logic [LW-1:0]   r_len4, r_d24;
    psd_pkg::t_part  r_part4;
    logic [PW-1:0]   r_hh, r_hl, r_ll;
    logic [DW-1:0]   n_hi, n_lo;
    logic            n_neg, n_gt;

    assign n_hi  = r_cmag[LW-1:DW];
    assign n_lo  = r_cmag[DW-1:0];
    assign n_neg = r_dot[DotW-1];
    assign n_gt  = !n_neg && (r_dot[DotW-2:0] > r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len4 <= r_len;
            r_hh   <= n_hi * n_hi;
            r_hl   <= n_hi * n_lo;
            r_ll   <= n_lo * n_lo;
            if (r_len == '0 || n_neg) begin
                r_part4 <= psd_pkg::PART_START;
                r_d24   <= r_d2a;
            end else if (n_gt) begin
                r_part4 <= psd_pkg::PART_END;
                r_d24   <= r_d2b;
            end else begin
                r_part4 <= psd_pkg::PART_INTERIOR;
                r_d24   <= r_d2a;
            end
        end
    end

    // stage 5: sum the partial squares
    logic            r_v5;
    logic [SqW-1:0]  r_sq;
    logic [LW-1:0]   r_len5, r_d25;
    psd_pkg::t_part  r_part5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= (SqW'(r_hh) << (2 * DW)) + (SqW'(r_hl) << (DW + 1)) + SqW'(r_ll);
            r_len5  <= r_len4;
            r_d25   <= r_d24;
            r_part5 <= r_part4;
        end
    end

    assign o_valid = r_v5;
    assign o_rem   = r_sq[SqW-1:LW];
    assign o_low   = r_sq[LW-1:0];
    assign o_len   = r_len5;
    assign o_d2    = r_d25;
    assign o_part  = r_part5;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### sv/psd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_div: pipelined restoring divider
// One quotient bit per stage; divides the squared cross, scaled by the
// fraction bits, by the squared length.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int LenW     = 34,
    parameter int FracBits = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [LenW-1:0]            i_rem,
    input  wire logic [LenW-1:0]            i_low,
    input  wire logic [LenW-1:0]            i_len,
    input  wire logic [LenW-1:0]            i_d2,
    input  psd_pkg::t_part                  i_part,
    output logic                            o_valid,
    output logic [LenW+2*FracBits-1:0]      o_quo,
    output logic [LenW-1:0]                 o_d2,
    output psd_pkg::t_part                  o_part
);
    localparam int QW = LenW + 2 * FracBits;

    logic            r_v    [QW];
    logic [LenW-1:0] r_rem  [QW];
    logic [QW-1:0]   r_num  [QW];
    logic [QW-1:0]   r_quo  [QW];
    logic [LenW-1:0] r_len  [QW];
    logic [LenW-1:0] r_d2   [QW];
    psd_pkg::t_part  r_part [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            c_v;
        logic [LenW-1:0] c_rem, c_len, c_d2;
        logic [QW-1:0]   c_num, c_quo;
        psd_pkg::t_part  c_part;
        logic [LenW:0]   c_rem2;
        logic            c_ge;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = i_rem;
            assign c_num  = QW'(i_low) << (2 * FracBits);
            assign c_quo  = '0;
            assign c_len  = i_len;
            assign c_d2   = i_d2;
            assign c_part = i_part;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_num  = r_num[k-1];
            assign c_quo  = r_quo[k-1];
            assign c_len  = r_len[k-1];
            assign c_d2   = r_d2[k-1];
            assign c_part = r_part[k-1];
        end

        // shift in the next numerator bit and try the subtract
        assign c_rem2 = {c_rem, c_num[QW-1]};
        assign c_ge   = c_rem2 >= {1'b0, c_len};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= LenW'(c_ge ? c_rem2 - {1'b0, c_len} : c_rem2);
                r_num[k]  <= c_num << 1;
                r_quo[k]  <= QW'({c_quo, c_ge});
                r_len[k]  <= c_len;
                r_d2[k]   <= c_d2;
                r_part[k] <= c_part;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_d2    = r_d2[QW-1];
    assign o_part  = r_part[QW-1];

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### sv/psd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_sqrt: pipelined integer square root
// One root bit per stage, digit-by-digit restoring method, floored result.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int RadW = 66
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [RadW-1:0]        i_rad,
    input  psd_pkg::t_part              i_part,
    output logic                        o_valid,
    output logic [(RadW+1)/2-1:0]       o_root,
    output psd_pkg::t_part              o_part
);
    localparam int SW   = (RadW + 1) / 2;
    localparam int PadW = 2 * SW;
    localparam int RemW = SW + 2;

    logic             r_v    [SW];
    logic [RemW-1:0]  r_rem  [SW];
    logic [PadW-1:0]  r_rad  [SW];
    logic [SW-1:0]    r_root [SW];
    psd_pkg::t_part   r_part [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic            c_v;
        logic [RemW-1:0] c_rem;
        logic [PadW-1:0] c_rad;
        logic [SW-1:0]   c_root;
        psd_pkg::t_part  c_part;
        logic [RemW+1:0] c_rem2, c_trial;
        logic            c_ge;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_rad  = PadW'(i_rad);
            assign c_root = '0;
            assign c_part = i_part;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_rad  = r_rad[k-1];
            assign c_root = r_root[k-1];
            assign c_part = r_part[k-1];
        end

        // bring down two radicand bits and test the trial root
        assign c_rem2  = {c_rem, c_rad[PadW-1 -: 2]};
        assign c_trial = (RemW + 2)'({c_root, 2'b01});
        assign c_ge    = c_rem2 >= c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= RemW'(c_ge ? c_rem2 - c_trial : c_rem2);
                r_rad[k]  <= c_rad << 2;
                r_root[k] <= SW'({c_root, c_ge});
                r_part[k] <= c_part;
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_part  = r_part[SW-1];

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### sv/point_segment_distance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_segment_distance_core: point to line segment distance, 2D
// Takes one request per cycle and returns one result per cycle, in order,
// unless the output is stalled. The pipe has Q = 2*COORD_WIDTH + 2 +
// 2*FRAC_BITS divider stages and S = ceil(Q/2) root stages after the front.
// The divider and root pipelines, one bit per stage, set the depth; the
// whole pipe holds while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module point_segment_distance_core #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [psd_pkg::DIST_W-1:0]         o_distance_q16,
    output logic [1:0]                         o_nearest_part
);
    localparam int LW   = 2 * (COORD_WIDTH + 1);
    localparam int QW   = LW + 2 * FRAC_BITS;
    localparam int SW   = (QW + 1) / 2;
    localparam int OutW = psd_pkg::DIST_W;

    logic            w_en;
    logic            w_fv, w_dv, w_sv;
    logic [LW-1:0]   w_rem, w_low, w_len, w_fd2, w_dd2;
    psd_pkg::t_part  w_fpart, w_dpart, w_spart;
    logic [QW-1:0]   w_quo, w_rad;
    logic [SW-1:0]   w_root;

    // advance unless a finished result is held by the receiver
    assign w_en    = !(w_sv && i_stall);
    assign o_stall = !w_en;

    psd_front #(.CoordW(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_ax    (i_start_x),
        .i_ay    (i_start_y),
        .i_bx    (i_end_x),
        .i_by    (i_end_y),
        .o_valid (w_fv),
        .o_rem   (w_rem),
        .o_low   (w_low),
        .o_len   (w_len),
        .o_d2    (w_fd2),
        .o_part  (w_fpart)
    );

    psd_div #(.LenW(LW), .FracBits(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_rem   (w_rem),
        .i_low   (w_low),
        .i_len   (w_len),
        .i_d2    (w_fd2),
        .i_part  (w_fpart),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_d2    (w_dd2),
        .o_part  (w_dpart)
    );

    // pick the perpendicular quotient or the scaled endpoint square
    assign w_rad = (w_dpart == psd_pkg::PART_INTERIOR) ? w_quo
                                                       : (QW'(w_dd2) << (2 * FRAC_BITS));

    psd_sqrt #(.RadW(QW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_rad   (w_rad),
        .i_part  (w_dpart),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_part  (w_spart)
    );

    assign o_valid        = w_sv;
    assign o_distance_q16 = OutW'(w_root);
    assign o_nearest_part = w_spart;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_segment_distance_core
// Drives point and segment requests with random gaps and output stalls, works
// out each distance and nearest part with exact wide integer arithmetic and
// compares every result, in order, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW        = 16;
    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1525;
    localparam int TAIL      = 140;
    localparam int CYCLE_CAP = 1000000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        logic [psd_pkg::DIST_W-1:0] distance;
        psd_pkg::t_part             part;
    } t_seg_result;

    // floor(sqrt(n)) over a 128-bit radicand
    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = {64'd0, r | (64'd1 << b)};
            if (t * t <= n) r = t[63:0];
        end
        return r;
    endfunction

    // distance from the point to the segment, with the nearest part
    function automatic t_seg_result seg_distance(input t_coord px, py, ax, ay, bx, by);
        t_seg_result  res;
        longint       a, b, c, d, dot, len, cr, ex, ey;
        logic [127:0] num;
        logic [63:0]  root;
        a   = longint'(px) - longint'(ax);
        b   = longint'(py) - longint'(ay);
        c   = longint'(bx) - longint'(ax);
        d   = longint'(by) - longint'(ay);
        dot = a * c + b * d;
        len = c * c + d * d;
        if (len == 0 || dot < 0 || dot > len) begin
            if (len == 0 || dot < 0) begin
                ex = a;
                ey = b;
                res.part = psd_pkg::PART_START;
            end else begin
                ex = longint'(px) - longint'(bx);
                ey = longint'(py) - longint'(by);
                res.part = psd_pkg::PART_END;
            end
            num  = 128'(ex * ex + ey * ey) << (2 * FRAC);
            root = root_floor(num);
        end else begin
            cr = a * d - b * c;
            if (cr < 0) cr = -cr;
            num  = (128'(cr) * 128'(cr)) << (2 * FRAC);
            num  = num / 128'(len);
            root = root_floor(num);
            res.part = psd_pkg::PART_INTERIOR;
        end
        res.distance = root[psd_pkg::DIST_W-1:0];
        return res;
    endfunction

    // outstanding predictions, oldest first
    class distance_board;
        t_seg_result awaited[$];

        function void note_request(t_coord px, py, ax, ay, bx, by);
            awaited.push_back(seg_distance(px, py, ax, ay, bx, by));
        endfunction

        // empty string when the result matches
        function string check_result(logic [psd_pkg::DIST_W-1:0] distance, logic [1:0] part);
            t_seg_result e;
            if (awaited.size() == 0) return "result with no request outstanding";
            e = awaited.pop_front();
            if (distance !== e.distance || part !== e.part)
                return $sformatf("distance %0d part %0d, predicted %0d part %0d",
                                 distance, part, e.distance, e.part);
            return "";
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       i_stall = 1'b0;
    t_coord                     i_point_x = '0, i_point_y = '0;
    t_coord                     i_start_x = '0, i_start_y = '0;
    t_coord                     i_end_x = '0, i_end_y = '0;
    logic                       o_stall, o_valid;
    logic [psd_pkg::DIST_W-1:0] o_distance_q16;
    logic [1:0]                 o_nearest_part;

    distance_board board = new();
    int  mismatches = 0;
    int  cycles = 0;
    bit  sending_done = 1'b0;

    point_segment_distance_core #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // no gap most often, else mostly short gaps, the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_request(input t_coord px, py, ax, ay, bx, by);
        @(negedge i_clk);
        i_point_x = px; i_point_y = py;
        i_start_x = ax; i_start_y = ay;
        i_end_x   = bx; i_end_y   = by;
        i_valid   = 1'b1;
        // hold until the block takes the request
        do @(posedge i_clk); while (o_stall);
        board.note_request(px, py, ax, ay, bx, by);
        for (int g = gap_len(); g > 0; g--) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // drop valid and hold off until every outstanding result has come
    task automatic drain_requests();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
    endtask

    // random request; clustered shapes reach every nearest-part branch
    task automatic random_request();
        t_coord px, py, ax, ay, bx, by;
        int     shape, span;
        shape = $urandom_range(0, 9);
        px = t_coord'($urandom); py = t_coord'($urandom);
        ax = t_coord'($urandom); ay = t_coord'($urandom);
        bx = t_coord'($urandom); by = t_coord'($urandom);
        if (shape >= 4) begin
            span = (shape == 9) ? 3 : 200;
            ax = px + t_coord'($urandom_range(0, 2 * span) - span);
            ay = py + t_coord'($urandom_range(0, 2 * span) - span);
            bx = px + t_coord'($urandom_range(0, 2 * span) - span);
            by = py + t_coord'($urandom_range(0, 2 * span) - span);
        end
        if (shape == 3) begin
            bx = ax;
            by = ay;
        end
        send_request(px, py, ax, ay, bx, by);
    endtask

    // output side: random stalls, long ones now and then
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = gap_len();
            @(negedge i_clk);
            i_stall = (n != 0);
            for (int k = 1; k < n; k++) @(negedge i_clk);
            n = $urandom_range(1, 12);
            @(negedge i_clk);
            i_stall = 1'b0;
            for (int k = 1; k < n; k++) @(negedge i_clk);
        end
    end

    // check results as they are taken
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            msg = board.check_result(o_distance_q16, o_nearest_part);
            if (msg != "") report(msg);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        localparam t_coord MAXC = 16'sh7FFF;
        localparam t_coord MINC = 16'sh8000;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, degenerate segment, each nearest part, ties
        send_request(MAXC, MAXC, MINC, MINC, MINC, MINC);
        send_request(MINC, MINC, MAXC, MAXC, MAXC, MAXC);
        send_request(MAXC, MINC, MINC, MAXC, MINC, MAXC);
        send_request(MINC, MAXC, MAXC, MINC, MINC, MINC);
        send_request(MAXC, MAXC, MINC, MINC, MINC, MAXC);
        send_request(MINC, MINC, MAXC, MINC, MINC, MAXC);
        send_request(MAXC, MINC, MINC, MAXC, MAXC, MINC);
        send_request(0, 0, 0, 0, 0, 0);
        send_request(-1, -1, 0, 0, 0, 0);
        send_request(-5, 3, 0, 0, 10, 0);
        send_request(15, -3, 0, 0, 10, 0);
        send_request(4, 7, 0, 0, 10, 0);
        send_request(0, 9, 0, 0, 10, 0);
        send_request(10, -9, 0, 0, 10, 0);
        send_request(0, 0, 0, 0, 10, 0);
        send_request(10, 0, 0, 0, 10, 0);
        send_request(3, 4, 0, 0, 6, 8);
        send_request(1, 0, 0, 0, 2, 1);
        send_request(MINC, 0, MAXC, 0, MINC, 0);
        send_request(0, MAXC, 0, MINC, 0, MAXC);
        send_request(MAXC, MAXC, 1, -1, -1, 1);
        send_request(1, 2, 3, 4, 3, 4);
        send_request(-32767, 32767, 32767, -32767, -32768, -32768);

        // hold off until the pipe has drained
        drain_requests();

        for (int i = 0; i < N_RANDOM; i++) begin
            random_request();
            if (i == N_RANDOM / 2) drain_requests();
        end

        drain_requests();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0 && board.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
